// File: rtl/core/interval_overlap_merge_macros.svh
// Assertion macros shared by the interval merge RTL.
`ifndef INTERVAL_OVERLAP_MERGE_MACROS_SVH
`define INTERVAL_OVERLAP_MERGE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define IOM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define IOM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/iom_pkg.sv
// Shared types and constants for the interval merge block.
package iom_pkg;

    localparam int MAX_REGIONS = 32;
    localparam int INDEX_BITS  = 16;
    localparam int FIELD_W     = 16;
    localparam int TDATA_W     = 2 * FIELD_W;
    localparam int IDX_W       = $clog2(MAX_REGIONS);
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

    // indices narrower than the field keep only their low INDEX_BITS bits
    localparam logic [FIELD_W-1:0] INDEX_MASK =
        (INDEX_BITS >= FIELD_W) ? {FIELD_W{1'b1}} : FIELD_W'((64'd1 << INDEX_BITS) - 64'd1);

    typedef struct packed {
        logic [FIELD_W-1:0] end_idx;
        logic [FIELD_W-1:0] start_idx;
    } entry_t;

    typedef struct packed {
        logic   hit;
        entry_t merged;
    } union_res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPEND,
        ST_EMIT
    } state_t;

endpackage

// File: rtl/core/iom_union.sv
// Overlap test and union of one stored entry with the incoming interval.
module iom_union (
    input  iom_pkg::entry_t             stored,
    input  logic [iom_pkg::FIELD_W-1:0] lo,
    input  logic [iom_pkg::FIELD_W-1:0] hi,
    output iom_pkg::union_res_t         res
);

    always_comb
    begin
        res.hit              = (stored.start_idx <= hi) && (stored.end_idx >= lo);
        res.merged.start_idx = (lo < stored.start_idx) ? lo : stored.start_idx;
        res.merged.end_idx   = (hi > stored.end_idx) ? hi : stored.end_idx;
    end

endmodule

// File: rtl/core/interval_overlap_merge.sv
// Interval merge top level: table memory, scan/append/emit sequencer, output register.
// Scan: the single read port walks the held entries in order (count = entries held);
// an item merges into the first it overlaps, else is appended. New items wait for idle.
// Emission: each merged interval takes a memory read, then an output register load.
// Reset: rst_n async low clears count, overflow flag, sequencer and output valid.
// Table memory is not cleared; only entries below the count are ever read.
`include "interval_overlap_merge_macros.svh"

module interval_overlap_merge (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [iom_pkg::TDATA_W-1:0]  s_axis_tdata,   // region_start, region_end
    input  logic                         s_axis_tlast,   // final_item
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [iom_pkg::TDATA_W-1:0]  m_axis_tdata,   // merged_start, merged_end
    output logic                         m_axis_tlast,   // end_of_list
    output logic                         m_axis_tuser    // table_overflow
);

    localparam int FW = iom_pkg::FIELD_W;
    localparam int IW = iom_pkg::IDX_W;
    localparam int CW = iom_pkg::CNT_W;

    // sequencer and control state
    iom_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            ovf_reg, ovf_next;
    logic [CW-1:0]   rd_idx_reg, rd_idx_next;   // next entry to read
    logic            cmp_vld_reg, cmp_vld_next; // read data valid this cycle
    logic            m_valid_reg, m_valid_next;

    // payload registers
    logic [IW-1:0]   cmp_idx_reg, cmp_idx_next; // entry whose data is on rd_data_reg
    logic [FW-1:0]   lo_reg, lo_next;
    logic [FW-1:0]   hi_reg, hi_next;
    logic            last_reg, last_next;
    logic [FW-1:0]   m_start_reg, m_end_reg;
    logic            m_last_reg, m_ovf_reg;

    // table memory, one read port and one write port
    iom_pkg::entry_t mem [iom_pkg::MAX_REGIONS];
    iom_pkg::entry_t rd_data_reg;
    logic            rd_en;
    logic [IW-1:0]   rd_addr;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    iom_pkg::entry_t wr_data;

    iom_pkg::union_res_t ures;
    logic                cmp_last;   // entry on the read port is the last valid one
    logic                out_load;
    logic                out_free;

    iom_union u_union (
        .stored (rd_data_reg),
        .lo     (lo_reg),
        .hi     (hi_reg),
        .res    (ures)
    );

    assign cmp_last = (CW'(cmp_idx_reg) == (count_reg - CW'(1)));
    assign out_free = !m_valid_reg || m_axis_tready;

    // Reads and writes never touch the same entry in one cycle: a write only
    // ends a scan or an append, and the next read comes after it.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        rd_idx_next  = rd_idx_reg;
        cmp_vld_next = cmp_vld_reg;
        cmp_idx_next = cmp_idx_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        last_next    = last_reg;
        rd_en        = 1'b0;
        rd_addr      = rd_idx_reg[IW-1:0];
        wr_en        = 1'b0;
        wr_addr      = cmp_idx_reg;
        wr_data      = ures.merged;
        out_load     = 1'b0;
        s_axis_tready = 1'b0;

        unique case (state_reg)
            iom_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    lo_next      = s_axis_tdata[FW-1:0] & iom_pkg::INDEX_MASK;
                    hi_next      = s_axis_tdata[2*FW-1:FW] & iom_pkg::INDEX_MASK;
                    last_next    = s_axis_tlast;
                    rd_idx_next  = '0;
                    cmp_vld_next = 1'b0;
                    state_next   = (count_reg == '0) ? iom_pkg::ST_APPEND : iom_pkg::ST_SCAN;
                end
            end

            iom_pkg::ST_SCAN:
            begin
                // reads stream out one per cycle; each is compared in the cycle after its read
                if (cmp_vld_reg && ures.hit)
                begin
                    wr_en        = 1'b1;
                    rd_idx_next  = '0;
                    cmp_vld_next = 1'b0;
                    state_next   = last_reg ? iom_pkg::ST_EMIT : iom_pkg::ST_IDLE;
                end
                else
                begin
                    rd_en        = (rd_idx_reg < count_reg);
                    rd_idx_next  = rd_idx_reg + CW'(rd_en);
                    cmp_vld_next = rd_en;
                    cmp_idx_next = rd_idx_reg[IW-1:0];
                    if (cmp_vld_reg && cmp_last)
                    begin
                        state_next = iom_pkg::ST_APPEND;
                    end
                end
            end

            iom_pkg::ST_APPEND:
            begin
                if (count_reg < CW'(iom_pkg::MAX_REGIONS))
                begin
                    wr_en      = 1'b1;
                    wr_addr    = count_reg[IW-1:0];
                    wr_data    = '{end_idx: hi_reg, start_idx: lo_reg};
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    ovf_next = 1'b1;   // table full, interval dropped
                end
                rd_idx_next  = '0;
                cmp_vld_next = 1'b0;
                state_next   = last_reg ? iom_pkg::ST_EMIT : iom_pkg::ST_IDLE;
            end

            iom_pkg::ST_EMIT:
            begin
                if (cmp_vld_reg)
                begin
                    out_load     = 1'b1;
                    cmp_vld_next = 1'b0;
                    if (cmp_last)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = iom_pkg::ST_IDLE;
                    end
                end
                else if ((rd_idx_reg < count_reg) && out_free)
                begin
                    // output register is empty by the time this data lands
                    rd_en        = 1'b1;
                    rd_idx_next  = rd_idx_reg + CW'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_idx_reg[IW-1:0];
                end
            end

            default:
            begin
                state_next = iom_pkg::ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= iom_pkg::ST_IDLE;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            rd_idx_reg  <= '0;
            cmp_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            rd_idx_reg  <= rd_idx_next;
            cmp_vld_reg <= cmp_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        last_reg    <= last_next;
        if (out_load)
        begin
            m_start_reg <= rd_data_reg.start_idx;
            m_end_reg   <= rd_data_reg.end_idx;
            m_last_reg  <= cmp_last;
            m_ovf_reg   <= ovf_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_end_reg, m_start_reg};
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_ovf_reg;

    `IOM_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CW'(iom_pkg::MAX_REGIONS), "entry count above table depth")
    `IOM_ASSERT_NOW(a_write_state, wr_en, (state_reg == iom_pkg::ST_SCAN) || (state_reg == iom_pkg::ST_APPEND), "table write outside scan or append")
    `IOM_ASSERT_NOW(a_read_bound, rd_en, rd_idx_reg < count_reg, "table read beyond valid entries")
    `IOM_ASSERT_NOW(a_no_overwrite, out_load, !m_valid_reg, "emit load over a pending transaction")
    `IOM_ASSERT_NEXT(a_emit_done, out_load && cmp_last, (count_reg == '0) && !ovf_reg && (state_reg == iom_pkg::ST_IDLE), "table not cleared after last emit")

endmodule

// File: dv/interval_overlap_merge_tb.sv
// Self-checking stream testbench for the interval merge block.
module interval_overlap_merge_tb;
    import iom_pkg::*;

    // One emitted merged interval, as it travels on the master side.
    typedef struct packed {
        logic [FIELD_W-1:0] lo;
        logic [FIELD_W-1:0] hi;
        logic               last;
        logic               ovf;
    } merged_span_t;

    // Directed stimulus row; rows with a typed answer form a one-interval list.
    typedef struct packed {
        logic [FIELD_W-1:0] lo;
        logic [FIELD_W-1:0] hi;
        logic               fin;
        logic               typed;
        logic [FIELD_W-1:0] ans_lo;
        logic [FIELD_W-1:0] ans_hi;
    } stim_row_t;

    localparam int N_DIRECTED = 22;
    localparam int N_RANDOM   = 300;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [TDATA_W-1:0]  s_axis_tdata;   // region_start, region_end
    logic                s_axis_tlast;   // final_item
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;   // merged_start, merged_end
    logic                m_axis_tlast;   // end_of_list
    logic                m_axis_tuser;   // table_overflow

    // Predictor copy of the merge table.
    logic [FIELD_W-1:0]  tbl_lo [MAX_REGIONS];
    logic [FIELD_W-1:0]  tbl_hi [MAX_REGIONS];
    int                  tbl_used;
    bit                  tbl_dropped;

    merged_span_t        due_spans[$];
    int                  err_count;
    int                  items_sent;
    int                  lists_done;
    int                  spans_checked;
    int                  overflow_lists;
    int                  burst_left;

    stim_row_t dir_rows [N_DIRECTED] = '{
        // extremes, each its own one-interval list
        '{16'h0000, 16'hffff, 1'b1, 1'b1, 16'h0000, 16'hffff},
        '{16'hffff, 16'hffff, 1'b1, 1'b1, 16'hffff, 16'hffff},
        '{16'h0000, 16'h0000, 1'b1, 1'b1, 16'h0000, 16'h0000},
        // inverted interval is kept as given
        '{16'hffff, 16'h0000, 1'b1, 1'b1, 16'hffff, 16'h0000},
        // third interval bridges the first two: widens only the first
        '{16'd100,  16'd200,  1'b0, 1'b0, 16'h0, 16'h0},
        '{16'd300,  16'd400,  1'b0, 1'b0, 16'h0, 16'h0},
        '{16'd150,  16'd350,  1'b1, 1'b0, 16'h0, 16'h0},
        // shared endpoint merges, adjacent-but-disjoint appends
        '{16'd500,  16'd600,  1'b0, 1'b0, 16'h0, 16'h0},
        '{16'd600,  16'd700,  1'b0, 1'b0, 16'h0, 16'h0},
        '{16'd400,  16'd499,  1'b0, 1'b0, 16'h0, 16'h0},
        '{16'd10,   16'd20,   1'b1, 1'b0, 16'h0, 16'h0},
        // inverted intervals against stored entries
        '{16'd1000, 16'd2000, 1'b0, 1'b0, 16'h0, 16'h0},
        '{16'd1500, 16'd1200, 1'b0, 1'b0, 16'h0, 16'h0},
        '{16'd2500, 16'd2400, 1'b0, 1'b0, 16'h0, 16'h0},
        '{16'd2450, 16'd2450, 1'b0, 1'b0, 16'h0, 16'h0},
        '{16'd3000, 16'd3000, 1'b1, 1'b0, 16'h0, 16'h0},
        // alternating bit patterns
        '{16'h5555, 16'haaaa, 1'b0, 1'b0, 16'h0, 16'h0},
        '{16'haaaa, 16'h5555, 1'b0, 1'b0, 16'h0, 16'h0},
        '{16'h0001, 16'h0001, 1'b0, 1'b0, 16'h0, 16'h0},
        '{16'hfffe, 16'hffff, 1'b1, 1'b0, 16'h0, 16'h0},
        // duplicate point interval on the final transaction
        '{16'd7,    16'd7,    1'b0, 1'b0, 16'h0, 16'h0},
        '{16'd7,    16'd7,    1'b1, 1'b0, 16'h0, 16'h0}
    };

    interval_overlap_merge u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("[%0t] mismatch %s: expected %0h, got %0h", $realtime, what, want, got);
        err_count++;
    endtask

    // Queue one expected span behind the ones already due.
    task automatic expect_span(input merged_span_t span);
        due_spans.insert(due_spans.size(), span);
    endtask

    // Fold one accepted interval into the table; on a final transaction queue the
    // whole table as expected spans (or the typed answer) and clear it.
    task automatic fold_interval(input logic [FIELD_W-1:0] lo_in,
                                 input logic [FIELD_W-1:0] hi_in,
                                 input logic fin, input logic typed,
                                 input merged_span_t typed_span);
        logic [FIELD_W-1:0] lo;
        logic [FIELD_W-1:0] hi;
        bit                 hit;
        merged_span_t       span;
        lo  = lo_in & INDEX_MASK;
        hi  = hi_in & INDEX_MASK;
        hit = 1'b0;
        for (int k = 0; k < tbl_used && !hit; k++)
        begin
            if (tbl_lo[k] <= hi && tbl_hi[k] >= lo)
            begin
                if (lo < tbl_lo[k]) tbl_lo[k] = lo;
                if (hi > tbl_hi[k]) tbl_hi[k] = hi;
                hit = 1'b1;
            end
        end
        if (!hit)
        begin
            if (tbl_used < MAX_REGIONS)
            begin
                tbl_lo[tbl_used] = lo;
                tbl_hi[tbl_used] = hi;
                tbl_used++;
            end
            else
                tbl_dropped = 1'b1;
        end
        if (fin)
        begin
            if (typed)
                expect_span(typed_span);
            else
            begin
                for (int k = 0; k < tbl_used; k++)
                begin
                    span.lo   = tbl_lo[k];
                    span.hi   = tbl_hi[k];
                    span.last = (k == tbl_used - 1);
                    span.ovf  = tbl_dropped;
                    expect_span(span);
                end
            end
            if (tbl_dropped) overflow_lists++;
            lists_done++;
            tbl_used    = 0;
            tbl_dropped = 1'b0;
        end
    endtask

    // Present one interval, with bursts and random gaps between them, and wait
    // until the transaction is taken.
    task automatic send_interval(input logic [FIELD_W-1:0] lo, input logic [FIELD_W-1:0] hi,
                                 input logic fin, input logic typed,
                                 input merged_span_t typed_span);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tdata  <= {hi, lo};
        s_axis_tlast  <= fin;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        fold_interval(lo, hi, fin, typed, typed_span);
        items_sent++;
    endtask

    // Hold the sender off until every expected span has been seen.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (due_spans.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Receiver back-pressure: a mode picked every so often, including a long
    // periodic stall and stretches of constant ready.
    int stall_tick = 0;
    int stall_mode = 0;
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 97 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= (stall_tick % 8) > 2;
            default: m_axis_tready <= (stall_tick % 32) >= 16;
        endcase
    end

    // Output checker: each span is compared with the oldest expectation.
    always @(posedge clk)
    begin
        merged_span_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (due_spans.size() == 0)
            begin
                $display("[%0t] unexpected transaction: start %0h end %0h", $realtime,
                         m_axis_tdata[FIELD_W-1:0], m_axis_tdata[TDATA_W-1:FIELD_W]);
                err_count++;
            end
            else
            begin
                want = due_spans.pop_front();
                spans_checked++;
                if (m_axis_tdata[FIELD_W-1:0] !== want.lo)
                    report_mismatch("merged_start", 32'(want.lo),
                                    32'(m_axis_tdata[FIELD_W-1:0]));
                if (m_axis_tdata[TDATA_W-1:FIELD_W] !== want.hi)
                    report_mismatch("merged_end", 32'(want.hi),
                                    32'(m_axis_tdata[TDATA_W-1:FIELD_W]));
                if (m_axis_tlast !== want.last)
                    report_mismatch("end_of_list", 32'(want.last), 32'(m_axis_tlast));
                if (m_axis_tuser !== want.ovf)
                    report_mismatch("table_overflow", 32'(want.ovf), 32'(m_axis_tuser));
            end
        end
    end

    initial
    begin
        int           rand_sent;
        int           kind;
        int           n;
        int           slot;
        int           base;
        int           lo;
        int           hi;
        int           tmp;
        merged_span_t typed_span;
        merged_span_t no_span;

        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        err_count      = 0;
        items_sent     = 0;
        lists_done     = 0;
        spans_checked  = 0;
        overflow_lists = 0;
        burst_left     = 0;
        tbl_used       = 0;
        tbl_dropped    = 1'b0;
        rand_sent      = 0;
        no_span        = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (int r = 0; r < N_DIRECTED; r++)
        begin
            typed_span.lo   = dir_rows[r].ans_lo;
            typed_span.hi   = dir_rows[r].ans_hi;
            typed_span.last = 1'b1;
            typed_span.ovf  = 1'b0;
            send_interval(dir_rows[r].lo, dir_rows[r].hi, dir_rows[r].fin,
                          dir_rows[r].typed, typed_span);
        end
        drain_results();

        // Random lists: clustered short lists, long lists that fill and often
        // overflow the table, and unconstrained noise.
        while (rand_sent < N_RANDOM)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 5)
            begin
                n    = $urandom_range(1, 6);
                base = $urandom_range(0, 65000);
                for (int i = 0; i < n; i++)
                begin
                    lo = base + $urandom_range(0, 400);
                    hi = lo + $urandom_range(0, 120);
                    if ($urandom_range(0, 9) == 0)
                    begin
                        tmp = lo; lo = hi; hi = tmp;
                    end
                    send_interval(lo[15:0], hi[15:0], i == n - 1, 1'b0, no_span);
                    rand_sent++;
                end
            end
            else if (kind < 7)
            begin
                // disjoint slots 1480 apart; some items land in an earlier slot
                n = $urandom_range(30, 44);
                for (int i = 0; i < n; i++)
                begin
                    slot = ($urandom_range(0, 7) == 0) ? $urandom_range(0, i) : i;
                    lo   = slot * 1480 + $urandom_range(0, 700);
                    hi   = lo + $urandom_range(0, 700);
                    send_interval(lo[15:0], hi[15:0], i == n - 1, 1'b0, no_span);
                    rand_sent++;
                end
            end
            else
            begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                begin
                    lo = $urandom_range(0, 65535);
                    hi = $urandom_range(0, 65535);
                    send_interval(lo[15:0], hi[15:0], i == n - 1, 1'b0, no_span);
                    rand_sent++;
                end
            end
            if ($urandom_range(0, 7) == 0)
                drain_results();
        end

        drain_results();
        repeat (80) @(posedge clk);

        $display("Covered %0d intervals in %0d lists (%0d with a full table dropping entries),",
                 items_sent, lists_done, overflow_lists);
        $display("checked %0d merged spans, %0d mismatches.", spans_checked, err_count);
        if (err_count == 0)
            $display("** interval_overlap_merge: PASSED **");
        else
            $display("** interval_overlap_merge: FAILED **");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial
    begin
        #2000000;
        $display("Timeout: %0d spans still expected", due_spans.size());
        $display("** interval_overlap_merge: FAILED **");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/iom_pkg.sv
rtl/core/iom_union.sv
rtl/core/interval_overlap_merge.sv
dv/interval_overlap_merge_tb.sv
